[sv/wsd_pkg.sv]
// Package: parse phase codes, result kind codes, length escapes and the result word type.
package wsd_pkg;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_UNMASKED = 2'd2;
  localparam logic [1:0] KIND_ORPHAN   = 2'd3;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [3:0] OP_CONTINUATION = 4'd0;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [1:0]  kind;
    logic [3:0]  message_opcode;
    logic        frame_final;
    logic        frame_end;
    logic        message_end;
    logic [31:0] message_offset;
  } wsd_result_t;

endpackage

[sv/wsd_if.sv]
// Interfaces: input byte channel and result word channel, valid/ready handshake.
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [1:0]  kind;
  logic [3:0]  message_opcode;
  logic        frame_final;
  logic        frame_end;
  logic        message_end;
  logic [31:0] message_offset;

  modport source (
    output valid, output payload_byte, output kind, output message_opcode,
    output frame_final, output frame_end, output message_end, output message_offset,
    input ready
  );
  modport sink (
    input valid, input payload_byte, input kind, input message_opcode,
    input frame_final, input frame_end, input message_end, input message_offset,
    output ready
  );
endinterface

[sv/wsd_parser.sv]
// Frame parser: header, extended length and mask key state, per-byte unmask and result build.
module wsd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         stream_byte,
  output logic               emit,
  output wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  logic [2:0]  parse_phase, parse_phase_next;
  logic        frame_fin, frame_fin_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic [3:0]  ext_bytes_left, ext_bytes_left_next;
  logic [63:0] payload_remaining, payload_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_phase, mask_phase_next;
  logic        fragment_active, fragment_active_next;
  logic [3:0]  saved_opcode, saved_opcode_next;
  logic [31:0] running_offset, running_offset_next;

  logic [3:0]  msg_op;
  logic [7:0]  key_byte;
  logic [63:0] remaining_dec;
  logic        fend;
  logic [3:0]  ext_dec;

  assign msg_op        = (frame_opcode == OP_CONTINUATION) ? saved_opcode : frame_opcode;
  assign remaining_dec = payload_remaining - 64'd1;
  assign fend          = (remaining_dec == 64'd0);
  assign ext_dec       = ext_bytes_left - 4'd1;

  always_comb begin
    unique case (mask_phase)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    parse_phase_next       = parse_phase;
    frame_fin_next         = frame_fin;
    frame_opcode_next      = frame_opcode;
    ext_bytes_left_next    = ext_bytes_left;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    mask_phase_next        = mask_phase;
    fragment_active_next   = fragment_active;
    saved_opcode_next      = saved_opcode;
    running_offset_next    = running_offset;
    emit                   = 1'b0;
    res                    = '0;

    unique case (parse_phase)
      PH_HDR0: begin
        frame_fin_next    = stream_byte[7];
        frame_opcode_next = stream_byte[3:0];
        parse_phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        if (!stream_byte[7] || (frame_opcode == OP_CONTINUATION && !fragment_active)) begin
          emit                 = 1'b1;
          res.kind             = stream_byte[7] ? KIND_ORPHAN : KIND_UNMASKED;
          res.message_opcode   = frame_opcode;
          res.frame_final      = frame_fin;
          fragment_active_next = 1'b0;
          saved_opcode_next    = '0;
          running_offset_next  = '0;
          parse_phase_next     = PH_HDR0;
        end else begin
          if (frame_opcode != OP_CONTINUATION) begin
            saved_opcode_next    = frame_opcode;
            running_offset_next  = '0;
            fragment_active_next = !frame_fin;
          end
          mask_key_next   = '0;
          mask_phase_next = '0;
          if (stream_byte[6:0] == LEN_EXT16 || stream_byte[6:0] == LEN_EXT64) begin
            payload_remaining_next = '0;
            ext_bytes_left_next    = (stream_byte[6:0] == LEN_EXT16) ? EXT16_BYTES
                                                                     : EXT64_BYTES;
            parse_phase_next       = PH_EXT;
          end else begin
            payload_remaining_next = {57'd0, stream_byte[6:0]};
            parse_phase_next       = PH_KEY;
          end
        end
      end
      PH_EXT: begin
        payload_remaining_next = {payload_remaining[55:0], stream_byte};
        ext_bytes_left_next    = ext_dec;
        if (ext_dec == 4'd0) begin
          parse_phase_next = PH_KEY;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], stream_byte};
        if (mask_phase != 2'd3) begin
          mask_phase_next = mask_phase + 2'd1;
        end else begin
          mask_phase_next = '0;
          if (payload_remaining == 64'd0) begin
            emit               = 1'b1;
            res.kind           = KIND_EMPTY;
            res.message_opcode = msg_op;
            res.frame_final    = frame_fin;
            res.frame_end      = 1'b1;
            res.message_end    = frame_fin;
            res.message_offset = running_offset;
            if (frame_fin) begin
              fragment_active_next = 1'b0;
            end
            parse_phase_next = PH_HDR0;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        emit                   = 1'b1;
        res.payload_byte       = stream_byte ^ key_byte;
        res.kind               = KIND_DATA;
        res.message_opcode     = msg_op;
        res.frame_final        = frame_fin;
        res.frame_end          = fend;
        res.message_end        = fend & frame_fin;
        res.message_offset     = running_offset;
        payload_remaining_next = remaining_dec;
        running_offset_next    = running_offset + 32'd1;
        mask_phase_next        = mask_phase + 2'd1;
        if (fend) begin
          if (frame_fin) begin
            fragment_active_next = 1'b0;
          end
          mask_phase_next  = '0;
          parse_phase_next = PH_HDR0;
        end
      end
      default: begin
        parse_phase_next = PH_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HDR0;
      frame_fin         <= 1'b0;
      frame_opcode      <= '0;
      ext_bytes_left    <= '0;
      payload_remaining <= '0;
      mask_key          <= '0;
      mask_phase        <= '0;
      fragment_active   <= 1'b0;
      saved_opcode      <= '0;
      running_offset    <= '0;
    end else if (take) begin
      parse_phase       <= parse_phase_next;
      frame_fin         <= frame_fin_next;
      frame_opcode      <= frame_opcode_next;
      ext_bytes_left    <= ext_bytes_left_next;
      payload_remaining <= payload_remaining_next;
      mask_key          <= mask_key_next;
      mask_phase        <= mask_phase_next;
      fragment_active   <= fragment_active_next;
      saved_opcode      <= saved_opcode_next;
      running_offset    <= running_offset_next;
    end
  end

endmodule

[sv/wsd_out_reg.sv]
// Result register: holds one result word for the downstream side, passes ready upstream.
module wsd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                emit,
  input  wsd_pkg::wsd_result_t res,
  output logic                in_ready,
  wsd_result_if.source        result
);
  import wsd_pkg::*;

  logic        valid;
  wsd_result_t data;

  assign in_ready = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= emit;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      data <= res;
    end
  end

  assign result.valid          = valid;
  assign result.payload_byte   = data.payload_byte;
  assign result.kind           = data.kind;
  assign result.message_opcode = data.message_opcode;
  assign result.frame_final    = data.frame_final;
  assign result.frame_end      = data.frame_end;
  assign result.message_end    = data.message_end;
  assign result.message_offset = data.message_offset;

endmodule

[sv/websocket_frame_deframer_unit.sv]
// Top level: WebSocket client frame deframer, one stream byte in, at most one result word out.
// Latency: a result word shows on the output in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the parser state and the single result register set it.
// A held result word stalls the input only while the downstream side is not ready.
// Reset (rst, synchronous, active high): parser back to expecting a first header byte,
// all frame and fragment state zero, result register empty.
module websocket_frame_deframer_unit (
  input logic          clk,
  input logic          rst,
  wsd_byte_if.sink     stream,
  wsd_result_if.source result
);
  import wsd_pkg::*;

  logic        take;
  logic        emit;
  logic        in_ready;
  wsd_result_t res;

  assign stream.ready = in_ready;
  assign take         = stream.valid && in_ready;

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .stream_byte (stream.stream_byte),
    .emit        (emit),
    .res         (res)
  );

  wsd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .emit     (emit),
    .res      (res),
    .in_ready (in_ready),
    .result   (result)
  );

endmodule

[sv/wsd_checker.sv]
// Checker: port-level properties of the deframer, bound to the top level.
module wsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic [1:0]  kind,
  input logic        frame_final,
  input logic        frame_end,
  input logic        message_end,
  input logic [31:0] message_offset
);
  import wsd_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(kind)
      && $stable(message_offset))
    else $error("result word changed while stalled");

  a_rise_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without a taken byte");

  a_message_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> frame_end && frame_final)
    else $error("message end outside a final frame end");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_UNMASKED || kind == KIND_ORPHAN)
      |-> payload_byte == 8'd0 && !frame_end && !message_end && message_offset == 32'd0)
    else $error("error word carries data fields");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> payload_byte == 8'd0 && frame_end)
    else $error("empty frame word malformed");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (stream.valid),
  .in_ready       (stream.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .payload_byte   (result.payload_byte),
  .kind           (result.kind),
  .frame_final    (result.frame_final),
  .frame_end      (result.frame_end),
  .message_end    (result.message_end),
  .message_offset (result.message_offset)
);
